### sv/crc16fr_pkg.sv
`timescale 1ns / 1ps
// types, codes and the crc byte update shared by the frame receiver modules
// no dependencies

package crc16fr_pkg;

    localparam logic [7:0]  START_BYTE = 8'h02;
    localparam logic [7:0]  END_BYTE   = 8'h03;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic [7:0]  TYPE_COUNT_RST = 8'd8;
    localparam logic [7:0]  KEEPALIVE_RST  = 8'd2;

    // configuration register indexes
    localparam logic [7:0]  REG_TYPE_COUNT = 8'd0;
    localparam logic [7:0]  REG_KEEPALIVE  = 8'd1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRCH = 3'd4,
        PH_CRCL = 3'd5,
        PH_TAIL = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_ACCEPT    = 3'd1,
        EV_BAD_START = 3'd2,
        EV_BAD_TYPE  = 3'd3,
        EV_CRC_FAIL  = 3'd4,
        EV_BAD_END   = 3'd5
    } t_event_kind;

    typedef struct packed {
        logic        emit;
        t_event_kind kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic        ack_wanted;
    } t_event;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/crc16fr_parser.sv
`timescale 1ns / 1ps
// frame parser: phase, running crc and held header fields, one byte per step
// depends on crc16fr_pkg

module crc16fr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_type_count,
    input  logic [7:0]           i_keepalive_type,
    output crc16fr_pkg::t_event  o_evt
);
    import crc16fr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [15:0] crc_upd;
    logic [7:0]  seen_inc;

    assign crc_upd  = crc16_byte(r_crc, i_byte);
    assign seen_inc = r_seen + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_crc   = r_crc;
        n_type  = r_type;
        n_len   = r_len;
        n_seen  = r_seen;
        o_evt   = '0;
        o_evt.frame_type   = r_type;
        o_evt.frame_length = r_len;
        case (r_phase)
            PH_TYPE: begin
                if (i_byte >= i_type_count) begin
                    n_phase = PH_IDLE;
                    o_evt.emit         = 1'b1;
                    o_evt.kind         = EV_BAD_TYPE;
                    o_evt.frame_type   = i_byte;
                    o_evt.frame_length = 8'd0;
                end else begin
                    n_crc   = crc_upd;
                    n_type  = i_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_crc   = crc_upd;
                n_len   = i_byte;
                n_seen  = 8'd0;
                n_phase = (i_byte == 8'd0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
                n_crc  = crc_upd;
                n_seen = seen_inc;
                if (seen_inc >= r_len) begin
                    n_phase = PH_CRCH;
                end
                o_evt.emit         = 1'b1;
                o_evt.kind         = EV_PAYLOAD;
                o_evt.payload_byte = i_byte;
                o_evt.byte_index   = r_seen;
            end
            PH_CRCH: begin
                n_crc   = crc_upd;
                n_phase = PH_CRCL;
            end
            PH_CRCL: begin
                n_crc = crc_upd;
                if (crc_upd != 16'h0000) begin
                    n_phase    = PH_IDLE;
                    o_evt.emit = 1'b1;
                    o_evt.kind = EV_CRC_FAIL;
                end else begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                n_phase    = PH_IDLE;
                o_evt.emit = 1'b1;
                if (i_byte != END_BYTE) begin
                    o_evt.kind = EV_BAD_END;
                end else begin
                    o_evt.kind       = EV_ACCEPT;
                    o_evt.ack_wanted = (r_type != i_keepalive_type);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte != START_BYTE) begin
                    o_evt.emit         = 1'b1;
                    o_evt.kind         = EV_BAD_START;
                    o_evt.frame_type   = 8'd0;
                    o_evt.frame_length = 8'd0;
                end else begin
                    n_crc   = CRC_INIT;
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_crc   <= CRC_INIT;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_len   <= n_len;
            r_seen  <= n_seen;
        end
    end

endmodule

### sv/crc16_frame_receiver_core.sv
`timescale 1ns / 1ps
// top level of the framed byte receiver with crc-16 check
// depends on crc16fr_pkg and crc16fr_parser

// Takes one received byte per transaction and parses frames of 0x02, type,
// length, payload, crc high, crc low, 0x03 (crc-16, poly 0x1021, init 0xffff,
// msb first, zero residue over type through crc low). Each payload byte comes
// out as an event, and the end of a frame or any error gives one more event.
// Bytes that produce no event (start, type, length, crc) give no output.
// A byte is registered on entry, and its event is loaded into the output
// register once that register is empty or not stalled; one byte per cycle
// is sustained unless an event waits on a full, stalled output register.
// Configuration writes are always ready and should be made while no frame is
// in flight.

module crc16_frame_receiver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // event output
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_frame_length,
    output logic       o_ack_wanted,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import crc16fr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_event     r_out;
    logic [7:0] r_type_count;
    logic [7:0] r_keepalive;
    logic       adv;
    logic       load_out;
    t_event     evt;

    // the input register moves on whenever the output register can take its event, or when its byte gives no event
    assign adv      = r_in_valid && (!r_out_valid || !i_stall || !evt.emit);
    assign load_out = adv && evt.emit;
    assign o_stall  = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    crc16fr_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (adv),
        .i_byte           (r_in_byte),
        .i_type_count     (r_type_count),
        .i_keepalive_type (r_keepalive),
        .o_evt            (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= evt;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_type   = r_out.frame_type;
    assign o_frame_length = r_out.frame_length;
    assign o_ack_wanted   = r_out.ack_wanted;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_count <= TYPE_COUNT_RST;
            r_keepalive  <= KEEPALIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TYPE_COUNT: r_type_count <= i_cfg_data;
                REG_KEEPALIVE:  r_keepalive  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // only payload events carry a byte and an index
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind != EV_PAYLOAD) |-> (o_payload_byte == 8'd0 && o_byte_index == 8'd0))
        else $error("non-payload event carries payload fields");

    // ack is only requested on an accepted frame
    a_ack_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ack_wanted) |-> (o_event_kind == EV_ACCEPT))
        else $error("ack flagged on event other than frame accepted");

    // a stalled output event is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !load_out)
        else $error("output register overwritten while stalled");

    // back-pressure upstream only with a byte waiting on a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without cause");

endmodule
